// File: rtl/ssr_pkg.sv
// Shared constants, field layout and types of the state-space regulator.
package ssr_pkg;

  // Word format: signed Q16.16.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned PROD_W = 2 * WORD_W - FRAC_W;
  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};

  // Coefficient store.
  localparam int unsigned ADDR_W = 7;
  localparam int unsigned STORE_DEPTH = 1 << ADDR_W;

  // Plant inputs y, r and v.
  localparam int unsigned NUM_INPUTS = 3;
  localparam int unsigned UIDX_W = 2;

  localparam int unsigned MAX_ORDER_DEF = 6;

  // Configuration register.
  localparam int unsigned CFG_W = 3;
  localparam logic [CFG_W-1:0] ORDER_RST = 3'd5;

  // Input item layout in tdata, lowest bit first.
  localparam int unsigned REQ_W = 2;
  localparam int unsigned IDX_LSB = 0;
  localparam int unsigned COEF_LSB = IDX_LSB + ADDR_W;
  localparam int unsigned INIT_LSB = COEF_LSB + WORD_W;
  localparam int unsigned MEAS_LSB = INIT_LSB + WORD_W;
  localparam int unsigned REF_LSB = MEAS_LSB + WORD_W;
  localparam int unsigned VREF_LSB = REF_LSB + WORD_W;
  localparam int unsigned IN_FIELDS_W = VREF_LSB + WORD_W;
  localparam int unsigned IN_DATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = WORD_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_INIT   = 2'd1,
    REQ_SAMPLE = 2'd2
  } ssr_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRIVE,
    ST_ROWS,
    ST_INIT,
    ST_WAIT_COPY,
    ST_TERM,
    ST_WAIT_TERM,
    ST_EMIT
  } ssr_state_e;

  // Where a finished sum is written.
  typedef enum logic [1:0] {
    DEST_DRIVE,
    DEST_STATE,
    DEST_TERM
  } ssr_dest_e;

endpackage

// File: rtl/state_space_regulator_unit.sv
// Discrete state-space regulator with one shared multiply-accumulate unit.
//
// The block takes items on the s_axis channel. tuser carries the request kind:
// load writes one word into the 128-entry coefficient store, init scales the
// stored initial vector by init_value into the state and recomputes the
// output term C*x, and sample produces one result on m_axis: the drive
// D0*y + D1*r + D2*v + term, with a flag in tuser that is set when any sum of
// that step clipped. After the drive, the state is updated as A*x + B*u and
// the term is recomputed. The number of states in use comes from the
// state_order register, written on the cfg channel; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// A sample item holds tready low until it raises its result; an init item
// holds it low while it runs, and a load item not at all. All of it runs
// through a single 32x32 multiplier behind the registered coefficient read
// port, one product per cycle, with short drains where a sum needs the state
// just written. The result sits in an output register; if the receiver stalls,
// the next items are still taken and computed, and a sample waits only at
// its very end until the earlier result has been taken. Reset clears the
// state vector, the term and the output valid flag, and sets state_order to 5;
// the coefficient store is not cleared and must be loaded before use.
module state_space_regulator_unit #(
  parameter int unsigned MAX_ORDER = ssr_pkg::MAX_ORDER_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // coef_index, coef_value, init_value, measured, reference, velocity_ref
  input  logic [ssr_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // req_type
  input  logic [ssr_pkg::REQ_W-1:0]        s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // drive
  output logic [ssr_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // saturated
  output logic [0:0]                       m_axis_tuser_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ssr_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned RowW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int unsigned CntW = $clog2(MAX_ORDER + ssr_pkg::NUM_INPUTS + 1);
  localparam int unsigned AccW = ssr_pkg::PROD_W + CntW;
  localparam int unsigned AW = ssr_pkg::ADDR_W;
  localparam int unsigned WW = ssr_pkg::WORD_W;

  // Coefficient layout in the store.
  localparam int unsigned BBase = MAX_ORDER * MAX_ORDER;
  localparam int unsigned CBase = BBase + ssr_pkg::NUM_INPUTS * MAX_ORDER;
  localparam int unsigned DBase = CBase + MAX_ORDER;
  localparam int unsigned IBase = DBase + ssr_pkg::NUM_INPUTS + 1;

  ssr_pkg::ssr_state_e state_q, state_d;
  ssr_pkg::ssr_req_e   req;

  logic [CntW-1:0] row_q, row_d, col_q, col_d;
  logic [CntW-1:0] order_n, order_last, row_last_col, b_col;
  logic [ssr_pkg::CFG_W-1:0] state_order_q;

  logic signed [WW-1:0] x_q [MAX_ORDER];
  logic signed [WW-1:0] nx_q [MAX_ORDER];
  logic signed [WW-1:0] u_q [ssr_pkg::NUM_INPUTS];
  logic signed [WW-1:0] scale_q, term_q, drive_q;
  logic                 flag_q, is_sample_q;

  logic [WW-1:0] coef_mem [ssr_pkg::STORE_DEPTH];
  logic signed [WW-1:0] coef_rd_q;

  logic                 in_accept, mem_we, pipe_empty, out_free;
  logic                 copy_en, emit_en;
  logic                 issue_valid, issue_first, issue_last;
  ssr_pkg::ssr_dest_e   issue_dest;
  logic [AW-1:0]        issue_addr;
  logic signed [WW-1:0] issue_opnd;

  logic                 s1_valid_q, s1_first_q, s1_last_q;
  ssr_pkg::ssr_dest_e   s1_dest_q;
  logic [RowW-1:0]      s1_row_q;
  logic signed [WW-1:0] opnd_q;

  logic                 s2_valid_q, s2_first_q, s2_last_q;
  ssr_pkg::ssr_dest_e   s2_dest_q;
  logic [RowW-1:0]      s2_row_q;
  logic signed [ssr_pkg::PROD_W-1:0] prod_q;
  logic signed [2*WW-1:0] prod_full;

  logic signed [AccW-1:0] acc_q, acc_base, acc_sum;
  logic [AccW-WW:0]       acc_hi;
  logic                   clip;
  logic [WW-1:0]          sat_val;
  logic                   wr_en;

  logic                   m_valid_q;
  logic [WW-1:0]          m_data_q;
  logic                   m_flag_q;

  assign req        = ssr_pkg::ssr_req_e'(s_axis_tuser_i);
  assign in_accept  = s_axis_tvalid_i & s_axis_tready_o;
  assign mem_we     = in_accept && (req == ssr_pkg::REQ_LOAD);
  assign pipe_empty = !s1_valid_q && !s2_valid_q;
  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign cfg_ready_o = 1'b1;

  // Order in use, clamped to 1 .. MAX_ORDER.
  always_comb begin
    if (state_order_q == '0) begin
      order_n = CntW'(1);
    end else if (CntW'(state_order_q) > CntW'(MAX_ORDER)) begin
      order_n = CntW'(MAX_ORDER);
    end else begin
      order_n = CntW'(state_order_q);
    end
  end

  assign order_last   = order_n - CntW'(1);
  assign row_last_col = order_n + CntW'(ssr_pkg::NUM_INPUTS - 1);
  assign b_col        = col_q - order_n;

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssr_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (req)
            ssr_pkg::REQ_SAMPLE: state_d = ssr_pkg::ST_DRIVE;
            ssr_pkg::REQ_INIT:   state_d = ssr_pkg::ST_INIT;
            default:             state_d = ssr_pkg::ST_IDLE;
          endcase
        end
      end
      ssr_pkg::ST_DRIVE: begin
        if (col_q == CntW'(ssr_pkg::NUM_INPUTS - 1)) state_d = ssr_pkg::ST_ROWS;
      end
      ssr_pkg::ST_ROWS: begin
        if (col_q == row_last_col && row_q == order_last) state_d = ssr_pkg::ST_WAIT_COPY;
      end
      ssr_pkg::ST_INIT: begin
        if (row_q == order_last) state_d = ssr_pkg::ST_WAIT_COPY;
      end
      ssr_pkg::ST_WAIT_COPY: begin
        if (pipe_empty) state_d = ssr_pkg::ST_TERM;
      end
      ssr_pkg::ST_TERM: begin
        if (col_q == order_last) state_d = ssr_pkg::ST_WAIT_TERM;
      end
      ssr_pkg::ST_WAIT_TERM: begin
        if (pipe_empty) state_d = is_sample_q ? ssr_pkg::ST_EMIT : ssr_pkg::ST_IDLE;
      end
      ssr_pkg::ST_EMIT: begin
        if (out_free) state_d = ssr_pkg::ST_IDLE;
      end
      default: state_d = ssr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: issue of one multiply-accumulate per cycle in the issuing states, and counters.
  always_comb begin
    s_axis_tready_o = 1'b0;
    issue_valid     = 1'b0;
    issue_first     = 1'b0;
    issue_last      = 1'b0;
    issue_dest      = ssr_pkg::DEST_STATE;
    issue_addr      = '0;
    issue_opnd      = '0;
    copy_en         = 1'b0;
    emit_en         = 1'b0;
    row_d           = row_q;
    col_d           = col_q;
    unique case (state_q)
      ssr_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        row_d = '0;
        col_d = '0;
      end
      ssr_pkg::ST_DRIVE: begin
        issue_valid = 1'b1;
        issue_dest  = ssr_pkg::DEST_DRIVE;
        issue_addr  = AW'(DBase) + AW'(col_q);
        issue_opnd  = u_q[col_q[ssr_pkg::UIDX_W-1:0]];
        issue_first = (col_q == '0);
        issue_last  = (col_q == CntW'(ssr_pkg::NUM_INPUTS - 1));
        col_d       = issue_last ? '0 : col_q + CntW'(1);
      end
      ssr_pkg::ST_ROWS: begin
        issue_valid = 1'b1;
        issue_dest  = ssr_pkg::DEST_STATE;
        if (col_q < order_n) begin
          issue_addr = AW'(MAX_ORDER) * AW'(row_q) + AW'(col_q);
          issue_opnd = x_q[col_q[RowW-1:0]];
        end else begin
          issue_addr = AW'(BBase) + AW'(ssr_pkg::NUM_INPUTS) * AW'(row_q) + AW'(b_col);
          issue_opnd = u_q[b_col[ssr_pkg::UIDX_W-1:0]];
        end
        issue_first = (col_q == '0);
        issue_last  = (col_q == row_last_col);
        if (issue_last) begin
          col_d = '0;
          row_d = row_q + CntW'(1);
        end else begin
          col_d = col_q + CntW'(1);
        end
      end
      ssr_pkg::ST_INIT: begin
        issue_valid = 1'b1;
        issue_dest  = ssr_pkg::DEST_STATE;
        issue_addr  = AW'(IBase) + AW'(row_q);
        issue_opnd  = scale_q;
        issue_first = 1'b1;
        issue_last  = 1'b1;
        row_d       = row_q + CntW'(1);
      end
      ssr_pkg::ST_WAIT_COPY: begin
        copy_en = pipe_empty;
        col_d   = '0;
      end
      ssr_pkg::ST_TERM: begin
        issue_valid = 1'b1;
        issue_dest  = ssr_pkg::DEST_TERM;
        issue_addr  = AW'(CBase) + AW'(col_q);
        issue_opnd  = x_q[col_q[RowW-1:0]];
        issue_first = (col_q == '0);
        issue_last  = (col_q == order_last);
        col_d       = col_q + CntW'(1);
      end
      ssr_pkg::ST_WAIT_TERM: begin
      end
      ssr_pkg::ST_EMIT: begin
        emit_en = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ssr_pkg::ST_IDLE;
      row_q         <= '0;
      col_q         <= '0;
      state_order_q <= ssr_pkg::ORDER_RST;
      is_sample_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      if (cfg_valid_i) begin
        state_order_q <= cfg_data_i;
      end
      if (in_accept) begin
        is_sample_q <= (req == ssr_pkg::REQ_SAMPLE);
      end
    end
  end

  // Operands held for the duration of one item.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      scale_q <= s_axis_tdata_i[ssr_pkg::INIT_LSB +: WW];
      u_q[0]  <= s_axis_tdata_i[ssr_pkg::MEAS_LSB +: WW];
      u_q[1]  <= s_axis_tdata_i[ssr_pkg::REF_LSB +: WW];
      u_q[2]  <= s_axis_tdata_i[ssr_pkg::VREF_LSB +: WW];
    end
  end

  // Coefficient store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      coef_mem[s_axis_tdata_i[ssr_pkg::IDX_LSB +: AW]] <= s_axis_tdata_i[ssr_pkg::COEF_LSB +: WW];
    end
    coef_rd_q <= coef_mem[issue_addr];
  end

  // Stage 1: coefficient read and operand. Stage 2: truncated product.
  assign prod_full = coef_rd_q * opnd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue_valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= issue_first;
    s1_last_q  <= issue_last;
    s1_dest_q  <= issue_dest;
    s1_row_q   <= row_q[RowW-1:0];
    opnd_q     <= issue_opnd;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_dest_q  <= s1_dest_q;
    s2_row_q   <= s1_row_q;
    // Dropping the low fraction bits of a two's complement product floors it.
    prod_q     <= prod_full[2*WW-1:ssr_pkg::FRAC_W];
  end

  // Stage 3: wide accumulate, then saturate when the sum is complete.
  always_comb begin
    if (s2_first_q) begin
      acc_base = (s2_dest_q == ssr_pkg::DEST_DRIVE) ? AccW'(term_q) : '0;
    end else begin
      acc_base = acc_q;
    end
    acc_sum = acc_base + AccW'(prod_q);
    acc_hi  = acc_sum[AccW-1:WW-1];
    clip    = !((&acc_hi) || !(|acc_hi));
    if (clip) begin
      sat_val = acc_sum[AccW-1] ? ssr_pkg::WORD_MIN : ssr_pkg::WORD_MAX;
    end else begin
      sat_val = acc_sum[WW-1:0];
    end
  end

  assign wr_en = s2_valid_q && s2_last_q;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      acc_q <= acc_sum;
    end
    if (wr_en && s2_dest_q == ssr_pkg::DEST_DRIVE) begin
      drive_q <= sat_val;
    end
    if (wr_en && s2_dest_q == ssr_pkg::DEST_STATE) begin
      nx_q[s2_row_q] <= sat_val;
    end
  end

  // Architectural state: x, the output term and the step's clip flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        x_q[i] <= '0;
      end
      term_q <= '0;
      flag_q <= 1'b0;
    end else begin
      if (copy_en) begin
        // States beyond the order in use keep their old values.
        for (int i = 0; i < MAX_ORDER; i++) begin
          if (CntW'(i) < order_n) begin
            x_q[i] <= nx_q[i];
          end
        end
      end
      if (wr_en && s2_dest_q == ssr_pkg::DEST_TERM) begin
        term_q <= sat_val;
      end
      if (in_accept) begin
        flag_q <= 1'b0;
      end else if (wr_en && clip) begin
        flag_q <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit_en) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      m_data_q <= drive_q;
      m_flag_q <= flag_q;
    end
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = m_data_q;
  assign m_axis_tuser_o[0] = m_flag_q;

  // The MAC pipeline is always drained while the block waits for items.
  a_idle_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ssr_pkg::ST_IDLE |-> !s1_valid_q && !s2_valid_q)
    else $error("MAC pipeline busy while idle");

  // The pipeline never stalls: every issued product reaches the accumulator.
  a_pipe_advances : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> s2_valid_q)
    else $error("MAC pipeline dropped an operation");

  // The drive sum completes while the state rows are being issued.
  a_drive_in_rows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && s2_dest_q == ssr_pkg::DEST_DRIVE |-> state_q == ssr_pkg::ST_ROWS)
    else $error("drive sum finished outside the row phase");

  // Reads stay inside the used part of the coefficient layout.
  a_addr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_valid |-> issue_addr < AW'(IBase + MAX_ORDER))
    else $error("coefficient address out of layout");

  // A result is only raised at the end of a sample item.
  a_emit_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == ssr_pkg::ST_EMIT)
    else $error("result raised outside the emit step");

endmodule

// File: tb/sv/tb_state_space_regulator_unit.sv
// Self-checking testbench for the state-space regulator unit.
`timescale 1ns / 100ps

module tb_state_space_regulator_unit;

  localparam int unsigned MAX_ORDER = ssr_pkg::MAX_ORDER_DEF;

  // Coefficient store layout for the default order.
  localparam int unsigned A_BASE = 0;
  localparam int unsigned B_BASE = A_BASE + MAX_ORDER * MAX_ORDER;
  localparam int unsigned C_BASE = B_BASE + ssr_pkg::NUM_INPUTS * MAX_ORDER;
  localparam int unsigned D_BASE = C_BASE + MAX_ORDER;
  localparam int unsigned INIT_BASE = D_BASE + ssr_pkg::NUM_INPUTS + 1;

  // The fourth request code is not decoded by the block.
  localparam logic [ssr_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  // This covers any item that may still be in flight after the last result has
  // come out, including a sample at the largest order.
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned END_WAIT_LIMIT = 50000;
  localparam int unsigned ITEMS_PER_PHASE = 180;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  localparam logic [ssr_pkg::WORD_W-1:0] Z = '0;
  localparam logic [ssr_pkg::WORD_W-1:0] ONE = 32'h0001_0000;
  localparam logic [ssr_pkg::WORD_W-1:0] HALF = 32'h0000_8000;

  typedef struct packed {
    logic [ssr_pkg::REQ_W-1:0]  req;
    logic [ssr_pkg::ADDR_W-1:0] index;
    logic [ssr_pkg::WORD_W-1:0] coef;
    logic [ssr_pkg::WORD_W-1:0] init_val;
    logic [ssr_pkg::WORD_W-1:0] meas;
    logic [ssr_pkg::WORD_W-1:0] ref_pos;
    logic [ssr_pkg::WORD_W-1:0] vel_ref;
  } item_t;

  typedef struct packed {
    logic [ssr_pkg::WORD_W-1:0] drive;
    logic                       saturated;
  } drive_t;

  typedef struct packed {
    item_t                      it;
    logic                       typed;
    logic [ssr_pkg::WORD_W-1:0] drive;
    logic                       saturated;
  } row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  logic [ssr_pkg::IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [ssr_pkg::REQ_W-1:0]      s_axis_tuser_i;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i;
  logic [ssr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [0:0]                     m_axis_tuser_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [ssr_pkg::CFG_W-1:0]      cfg_data_i;

  state_space_regulator_unit #(
    .MAX_ORDER(MAX_ORDER)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // Shadow copy of the regulator: store, state vector, output term, order.
  logic [ssr_pkg::WORD_W-1:0]        coef_mem [ssr_pkg::STORE_DEPTH];
  logic signed [ssr_pkg::WORD_W-1:0] x_vec [MAX_ORDER];
  logic signed [ssr_pkg::WORD_W-1:0] term_reg;
  logic [ssr_pkg::CFG_W-1:0]         order_reg;
  bit                                step_clipped;

  // Drives still owed by the block, oldest first.
  drive_t pending_drives [$];

  int          fail_count;
  int unsigned burst_left;
  int unsigned n_load, n_init, n_sample, n_ignored, n_orders;
  int unsigned n_results, n_sat_results;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Q16.16 product: an arithmetic shift of the exact product floors it.
  function automatic longint qmul(input logic signed [ssr_pkg::WORD_W-1:0] a,
                                  input logic signed [ssr_pkg::WORD_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> ssr_pkg::FRAC_W;
  endfunction

  function automatic logic signed [ssr_pkg::WORD_W-1:0] clip32(input longint s);
    if (s > S32_MAX) begin
      step_clipped = 1'b1;
      return ssr_pkg::WORD_MAX;
    end
    if (s < S32_MIN) begin
      step_clipped = 1'b1;
      return ssr_pkg::WORD_MIN;
    end
    return s[ssr_pkg::WORD_W-1:0];
  endfunction

  // Order 0 runs as one state and anything above the maximum as the maximum.
  function automatic int unsigned eff_order(input logic [ssr_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_ORDER) return MAX_ORDER;
    return int'(v);
  endfunction

  function automatic void update_term(input int unsigned n);
    longint acc;
    int unsigned j;
    acc = 0;
    for (j = 0; j < n; j++) acc += qmul(coef_mem[C_BASE + j], x_vec[j]);
    term_reg = clip32(acc);
  endfunction

  // Applies one accepted item to the shadow state and returns its drive.
  function automatic void regulator_step(input item_t it, output bit has_out,
                                         output drive_t res);
    int unsigned n, i, j, k;
    longint acc;
    logic signed [ssr_pkg::WORD_W-1:0] u [ssr_pkg::NUM_INPUTS];
    logic signed [ssr_pkg::WORD_W-1:0] nx [MAX_ORDER];
    n = eff_order(order_reg);
    step_clipped = 1'b0;
    has_out = 1'b0;
    res = '0;
    case (it.req)
      ssr_pkg::REQ_LOAD: begin
        coef_mem[it.index] = it.coef;
      end
      ssr_pkg::REQ_INIT: begin
        for (i = 0; i < n; i++) x_vec[i] = clip32(qmul(coef_mem[INIT_BASE + i], it.init_val));
        update_term(n);
      end
      ssr_pkg::REQ_SAMPLE: begin
        u[0] = it.meas;
        u[1] = it.ref_pos;
        u[2] = it.vel_ref;
        acc = longint'(term_reg);
        for (k = 0; k < ssr_pkg::NUM_INPUTS; k++) acc += qmul(coef_mem[D_BASE + k], u[k]);
        res.drive = clip32(acc);
        // The new state is built from the old one, so keep it apart until done.
        for (i = 0; i < n; i++) begin
          acc = 0;
          for (j = 0; j < n; j++) acc += qmul(coef_mem[A_BASE + MAX_ORDER * i + j], x_vec[j]);
          for (k = 0; k < ssr_pkg::NUM_INPUTS; k++)
            acc += qmul(coef_mem[B_BASE + ssr_pkg::NUM_INPUTS * i + k], u[k]);
          nx[i] = clip32(acc);
        end
        for (i = 0; i < n; i++) x_vec[i] = nx[i];
        update_term(n);
        res.saturated = step_clipped;
        has_out = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [ssr_pkg::IN_DATA_W-1:0] pack_item(input item_t it);
    logic [ssr_pkg::IN_DATA_W-1:0] d;
    d = '0;
    d[ssr_pkg::IDX_LSB +: ssr_pkg::ADDR_W] = it.index;
    d[ssr_pkg::COEF_LSB +: ssr_pkg::WORD_W] = it.coef;
    d[ssr_pkg::INIT_LSB +: ssr_pkg::WORD_W] = it.init_val;
    d[ssr_pkg::MEAS_LSB +: ssr_pkg::WORD_W] = it.meas;
    d[ssr_pkg::REF_LSB +: ssr_pkg::WORD_W] = it.ref_pos;
    d[ssr_pkg::VREF_LSB +: ssr_pkg::WORD_W] = it.vel_ref;
    return d;
  endfunction

  // Mostly zero or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  // Operand values: many small magnitudes keep the loop out of saturation,
  // full-range words and the extremes exercise clipping and every bit.
  function automatic logic [ssr_pkg::WORD_W-1:0] rand_word();
    int unsigned p;
    int v;
    p = $urandom_range(0, 99);
    if (p < 35) v = int'($urandom_range(0, 262144)) - 131072;
    else if (p < 50) v = int'($urandom_range(0, 8192)) - 4096;
    else if (p < 80) v = int'($urandom);
    else if (p < 85) v = int'(ssr_pkg::WORD_MAX);
    else if (p < 90) v = int'(ssr_pkg::WORD_MIN);
    else if (p < 95) v = 0;
    else v = -1;
    return v;
  endfunction

  // Gains stay mostly below a quarter so the state does not run away at once.
  function automatic logic [ssr_pkg::WORD_W-1:0] rand_coef();
    int v;
    if ($urandom_range(0, 99) < 70) begin
      v = int'($urandom_range(0, 32768)) - 16384;
      return v;
    end
    return rand_word();
  endfunction

  function automatic item_t random_item();
    item_t it;
    int unsigned p;
    it.index = ssr_pkg::ADDR_W'($urandom_range(0, ssr_pkg::STORE_DEPTH - 1));
    it.coef = rand_coef();
    it.init_val = rand_word();
    it.meas = rand_word();
    it.ref_pos = rand_word();
    it.vel_ref = rand_word();
    p = $urandom_range(0, 99);
    if (p < 30) it.req = ssr_pkg::REQ_LOAD;
    else if (p < 38) it.req = ssr_pkg::REQ_INIT;
    else if (p < 95) it.req = ssr_pkg::REQ_SAMPLE;
    else it.req = REQ_UNUSED;
    return it;
  endfunction

  function automatic row_t tbl_row(input logic [ssr_pkg::REQ_W-1:0] req,
                                   input int unsigned idx,
                                   input logic [ssr_pkg::WORD_W-1:0] cv,
                                   input logic [ssr_pkg::WORD_W-1:0] iv,
                                   input logic [ssr_pkg::WORD_W-1:0] y,
                                   input logic [ssr_pkg::WORD_W-1:0] r,
                                   input logic [ssr_pkg::WORD_W-1:0] v, input logic typed,
                                   input logic [ssr_pkg::WORD_W-1:0] drive, input logic sat);
    row_t rw;
    rw.it.req = req;
    rw.it.index = ssr_pkg::ADDR_W'(idx);
    rw.it.coef = cv;
    rw.it.init_val = iv;
    rw.it.meas = y;
    rw.it.ref_pos = r;
    rw.it.vel_ref = v;
    rw.typed = typed;
    rw.drive = drive;
    rw.saturated = sat;
    return rw;
  endfunction

  // Offers one item, waits for it to be taken and records what it should cause.
  // A known drive, where given, replaces the shadow model's for that item.
  task automatic send_item(input item_t it, input logic typed, input drive_t known);
    int unsigned gap;
    bit has_out;
    drive_t res;
    if (burst_left != 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
      gap = pick_gap();
    end
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= pack_item(it);
    s_axis_tuser_i <= it.req;
    do @(posedge clk_i); while (!s_axis_tready_o);
    regulator_step(it, has_out, res);
    if (has_out) pending_drives.push_back(typed ? known : res);
    case (it.req)
      ssr_pkg::REQ_LOAD: n_load++;
      ssr_pkg::REQ_INIT: n_init++;
      ssr_pkg::REQ_SAMPLE: n_sample++;
      default: n_ignored++;
    endcase
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_drives.size() != 0) @(posedge clk_i);
  endtask

  // The order may only change while the block is idle, so drain it first.
  task automatic set_state_order(input logic [ssr_pkg::CFG_W-1:0] v);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    order_reg = v;
    n_orders++;
  endtask

  // Result side: random stalls, with occasional long stretches always ready.
  initial begin
    int unsigned run, gap;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) run = $urandom_range(100, 300);
      else run = $urandom_range(1, 12);
      m_axis_tready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Every taken result is compared with the oldest expected drive.
  always @(posedge clk_i) begin
    drive_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_results++;
      if (m_axis_tuser_o[0]) n_sat_results++;
      if (pending_drives.size() == 0) begin
        $error("unexpected result: drive 0x%08h, saturated %0b", m_axis_tdata_o,
               m_axis_tuser_o[0]);
        fail_count++;
      end else begin
        want = pending_drives.pop_front();
        if (m_axis_tdata_o !== want.drive) begin
          $error("drive: expected 0x%08h, actual 0x%08h", want.drive, m_axis_tdata_o);
          fail_count++;
        end
        if (m_axis_tuser_o[0] !== want.saturated) begin
          $error("saturated: expected %0b, actual %0b", want.saturated, m_axis_tuser_o[0]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    row_t        dir_tbl [$];
    logic [ssr_pkg::CFG_W-1:0] phase_orders [$];
    item_t       it;
    int unsigned sent, wait_cycles, a;

    rst_ni <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    s_axis_tuser_i <= ssr_pkg::REQ_LOAD;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    fail_count = 0;
    burst_left = 0;
    order_reg = ssr_pkg::ORDER_RST;
    term_reg = '0;
    for (a = 0; a < MAX_ORDER; a++) x_vec[a] = '0;
    for (a = 0; a < ssr_pkg::STORE_DEPTH; a++) coef_mem[a] = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The store is undefined after reset, so write every entry with zero.
    it = '0;
    it.req = ssr_pkg::REQ_LOAD;
    for (a = 0; a < ssr_pkg::STORE_DEPTH; a++) begin
      it.index = ssr_pkg::ADDR_W'(a);
      send_item(it, 1'b0, '0);
    end

    // With all gains zero the drive is zero whatever the inputs.
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_SAMPLE, 0, Z, Z, Z, Z, Z, 1'b1, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_SAMPLE, 0, Z, Z, ssr_pkg::WORD_MAX,
                              ssr_pkg::WORD_MIN, '1, 1'b1, Z, 1'b0));
    // A full-scale gain on a full-scale input must clip both ways.
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_LOAD, D_BASE, ssr_pkg::WORD_MAX, Z, Z, Z, Z,
                              1'b0, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_SAMPLE, 0, Z, Z, ssr_pkg::WORD_MAX, Z, Z,
                              1'b1, ssr_pkg::WORD_MAX, 1'b1));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_SAMPLE, 0, Z, Z, ssr_pkg::WORD_MIN, Z, Z,
                              1'b1, ssr_pkg::WORD_MIN, 1'b1));
    // Half of minus one LSB floors to minus one LSB.
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_LOAD, D_BASE, HALF, Z, Z, Z, Z, 1'b0, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_SAMPLE, 0, Z, Z, '1, Z, Z, 1'b1, '1, 1'b0));
    // Unit gains on the first state, then an init and a few samples.
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_LOAD, B_BASE, ONE, Z, Z, Z, Z, 1'b0, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_LOAD, A_BASE, ONE, Z, Z, Z, Z, 1'b0, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_LOAD, C_BASE, ONE, Z, Z, Z, Z, 1'b0, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_LOAD, INIT_BASE, ONE, Z, Z, Z, Z, 1'b0, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_INIT, 0, Z, 32'h0003_0000, Z, Z, Z, 1'b0, Z,
                              1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_SAMPLE, 0, Z, Z, ONE, Z, Z, 1'b0, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_SAMPLE, 0, Z, Z, Z, Z, Z, 1'b0, Z, 1'b0));
    // An undecoded request must be taken and leave no trace.
    dir_tbl.push_back(tbl_row(REQ_UNUSED, 127, '1, '1, '1, '1, '1, 1'b0, Z, 1'b0));
    // An init that clips; its flag is never reported.
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_LOAD, INIT_BASE + 1, ssr_pkg::WORD_MAX, Z, Z, Z,
                              Z, 1'b0, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_LOAD, A_BASE + MAX_ORDER * 5 + 5,
                              ssr_pkg::WORD_MIN, Z, Z, Z, Z, 1'b0, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_INIT, 0, Z, ssr_pkg::WORD_MAX, Z, Z, Z, 1'b0, Z,
                              1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_SAMPLE, 0, Z, Z, ssr_pkg::WORD_MAX,
                              ssr_pkg::WORD_MAX, ssr_pkg::WORD_MAX, 1'b0, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_LOAD, ssr_pkg::STORE_DEPTH - 1, '1, Z, Z, Z, Z,
                              1'b0, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_LOAD, D_BASE + 1, ONE, Z, Z, Z, Z, 1'b0, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_LOAD, D_BASE + 2, 32'hFFFF_0000, Z, Z, Z, Z,
                              1'b0, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_SAMPLE, 0, Z, Z, Z, 32'h0005_0000, 32'h0002_0000,
                              1'b0, Z, 1'b0));
    dir_tbl.push_back(tbl_row(ssr_pkg::REQ_SAMPLE, 0, Z, Z, ssr_pkg::WORD_MIN,
                              ssr_pkg::WORD_MIN, ssr_pkg::WORD_MIN, 1'b0, Z, 1'b0));

    foreach (dir_tbl[r]) send_item(dir_tbl[r].it, dir_tbl[r].typed,
                                   {dir_tbl[r].drive, dir_tbl[r].saturated});

    // Random phases, one per order setting; the list includes the out-of-range
    // codes, the smallest and the largest order. States above a lowered order
    // must survive and come back when the order is raised again.
    phase_orders = '{3'd6, 3'd0, 3'd1, 3'd7, 3'd3, 3'd2, 3'd4, 3'd5};
    phase_orders.push_back(ssr_pkg::CFG_W'($urandom_range(0, 7)));
    foreach (phase_orders[p]) begin
      set_state_order(phase_orders[p]);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // Halfway through, hold the input until the block has caught up.
        if (sent == ITEMS_PER_PHASE / 2) wait_results_drained();
        it = random_item();
        send_item(it, 1'b0, '0);
        if (it.req != REQ_UNUSED) sent++;
      end
    end

    s_axis_tvalid_i <= 1'b0;
    wait_cycles = 0;
    while (pending_drives.size() != 0 && wait_cycles < END_WAIT_LIMIT) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_drives.size() != 0) begin
      $error("%0d expected drives never arrived", pending_drives.size());
      fail_count++;
    end

    $display("Sent %0d loads, %0d inits, %0d samples and %0d undecoded requests",
             n_load, n_init, n_sample, n_ignored);
    $display("over %0d order settings; %0d results checked, %0d of them clipped.",
             n_orders, n_results, n_sat_results);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
